@@ src/mac_address_table_assert.svh @@
// -----------------------------------------------------------------------------
// mac_address_table assertion macros
// Concurrent assertion shorthands clocked on clk and held off during reset.
// -----------------------------------------------------------------------------
`ifndef MAC_ADDRESS_TABLE_ASSERT_SVH
`define MAC_ADDRESS_TABLE_ASSERT_SVH

// Same-cycle implication.
`define MAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/mat_pkg.sv @@
// -----------------------------------------------------------------------------
// mat_pkg
// Sizes and command codes of the MAC address learning table.
// -----------------------------------------------------------------------------
package mat_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int PORT_COUNT    = 64;

  localparam int CMD_W  = 3;
  localparam int MAC_W  = 48;
  localparam int PORT_W = 6;
  localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SLOT_W = MAC_W + PORT_W;

  localparam logic [CMD_W-1:0] CMD_ADD         = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_MAC  = 3'd1;
  localparam logic [CMD_W-1:0] CMD_LOOKUP_PORT = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE      = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR       = 3'd4;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [SLOT_W-1:0] slot_t;

endpackage

@@ src/mac_address_table.sv @@
// -----------------------------------------------------------------------------
// mac_address_table
// Learned MAC address to port table, scanned one slot per cycle.
// -----------------------------------------------------------------------------
// One request is taken at a time. Add, lookup by address, lookup by port and
// remove by port walk the slot memory from slot 0 upward, one slot per cycle
// through the single read port with registered read data. A request that
// scans the whole table offers its result after the last slot is compared;
// an add or a lookup that hits stops at the matching slot. Clear, unknown
// commands and adds with an out-of-range port skip the scan and go straight
// to the result state. Valid bits live in flip-flops, so reset and clear
// empty the table at once; slot address and port are only read behind a set
// valid bit. The result sits in an output register, so the next request is
// accepted while it waits.
// -----------------------------------------------------------------------------
module mac_address_table (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [mat_pkg::CMD_W-1:0]  in_cmd,
  input  logic [mat_pkg::MAC_W-1:0]  in_mac_addr,
  input  logic [mat_pkg::PORT_W-1:0] in_port_id,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_found,
  output logic [mat_pkg::MAC_W-1:0]  out_found_mac,
  output logic [mat_pkg::PORT_W-1:0] out_found_port,
  output logic                      out_table_full
);
  import mat_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;
  localparam idx_t       LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

  // Control state
  logic [1:0]              state_r, state_nxt;
  logic                    rd_go_r, rd_go_nxt;
  logic                    cmp_vld_r, cmp_vld_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  // Request and result payload
  logic [CMD_W-1:0]  cmd_r, cmd_nxt;
  logic [MAC_W-1:0]  mac_r, mac_nxt;
  logic [PORT_W-1:0] port_r, port_nxt;
  idx_t              rd_idx_r, rd_idx_nxt;
  idx_t              cmp_idx_r, cmp_idx_nxt;
  logic              res_found_r, res_found_nxt;
  logic [MAC_W-1:0]  res_mac_r, res_mac_nxt;
  logic [PORT_W-1:0] res_port_r, res_port_nxt;
  logic              res_full_r, res_full_nxt;
  logic              out_found_r, out_found_nxt;
  logic [MAC_W-1:0]  out_mac_r, out_mac_nxt;
  logic [PORT_W-1:0] out_port_r, out_port_nxt;
  logic              out_full_r, out_full_nxt;

  // Slot memory: address in the upper bits, port in the lower bits
  slot_t             slot_mem [TABLE_ENTRIES];
  slot_t             rd_data_r;
  logic              mem_we;

  logic              in_fire;
  logic              port_ok;
  logic              slot_ok;
  logic              hit;
  logic              finish;
  logic [MAC_W-1:0]  rd_mac;
  logic [PORT_W-1:0] rd_port;

  assign in_ready = (state_r == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign port_ok  = (32'(in_port_id) < PORT_COUNT);

  assign rd_mac  = rd_data_r[SLOT_W-1:PORT_W];
  assign rd_port = rd_data_r[PORT_W-1:0];
  assign slot_ok = valid_r[cmp_idx_r];

  // Match test on the slot whose data just came out of memory
  always_comb begin
    case (cmd_r)
      CMD_ADD:         hit = !slot_ok;
      CMD_LOOKUP_MAC:  hit = slot_ok && (rd_mac == mac_r);
      CMD_LOOKUP_PORT: hit = slot_ok && (rd_port == port_r);
      CMD_REMOVE:      hit = slot_ok && (rd_port == port_r);
      default:         hit = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    rd_go_nxt     = rd_go_r;
    cmp_vld_nxt   = 1'b0;
    out_valid_nxt = out_valid_r;
    valid_nxt     = valid_r;
    cmd_nxt       = cmd_r;
    mac_nxt       = mac_r;
    port_nxt      = port_r;
    rd_idx_nxt    = rd_idx_r;
    cmp_idx_nxt   = cmp_idx_r;
    res_found_nxt = res_found_r;
    res_mac_nxt   = res_mac_r;
    res_port_nxt  = res_port_r;
    res_full_nxt  = res_full_r;
    out_found_nxt = out_found_r;
    out_mac_nxt   = out_mac_r;
    out_port_nxt  = out_port_r;
    out_full_nxt  = out_full_r;
    mem_we        = 1'b0;
    finish        = 1'b0;

    // Drain the output register
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd_nxt       = in_cmd;
          mac_nxt       = in_mac_addr;
          port_nxt      = in_port_id;
          res_found_nxt = 1'b0;
          res_mac_nxt   = '0;
          res_port_nxt  = '0;
          res_full_nxt  = 1'b0;
          rd_idx_nxt    = '0;
          rd_go_nxt     = 1'b1;
          case (in_cmd)
            CMD_ADD: begin
              state_nxt = port_ok ? ST_SCAN : ST_FIN;
            end
            CMD_LOOKUP_MAC, CMD_LOOKUP_PORT, CMD_REMOVE: begin
              state_nxt = ST_SCAN;
            end
            CMD_CLEAR: begin
              valid_nxt = '0;
              state_nxt = ST_FIN;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue the next slot read
        if (rd_go_r) begin
          cmp_vld_nxt = 1'b1;
          cmp_idx_nxt = rd_idx_r;
          if (rd_idx_r == LAST_IDX) begin
            rd_go_nxt = 1'b0;
          end else begin
            rd_idx_nxt = rd_idx_r + IDX_W'(1);
          end
        end
        // Compare the slot read last cycle
        if (cmp_vld_r) begin
          if (hit) begin
            case (cmd_r)
              CMD_ADD: begin
                mem_we                 = 1'b1;
                valid_nxt[cmp_idx_r]   = 1'b1;
                finish                 = 1'b1;
              end
              CMD_LOOKUP_MAC, CMD_LOOKUP_PORT: begin
                res_found_nxt = 1'b1;
                res_mac_nxt   = rd_mac;
                res_port_nxt  = rd_port;
                finish        = 1'b1;
              end
              CMD_REMOVE: begin
                valid_nxt[cmp_idx_r] = 1'b0;
              end
              default: begin
                finish = 1'b1;
              end
            endcase
          end
          if (cmp_idx_r == LAST_IDX && !finish) begin
            finish       = 1'b1;
            res_full_nxt = (cmd_r == CMD_ADD);
          end
        end
        if (finish) begin
          state_nxt   = ST_FIN;
          rd_go_nxt   = 1'b0;
          cmp_vld_nxt = 1'b0;
        end
      end

      ST_FIN: begin
        // Hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_mac_nxt   = res_mac_r;
          out_port_nxt  = res_port_r;
          out_full_nxt  = res_full_r;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rd_go_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
      valid_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      rd_go_r     <= rd_go_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    mac_r       <= mac_nxt;
    port_r      <= port_nxt;
    rd_idx_r    <= rd_idx_nxt;
    cmp_idx_r   <= cmp_idx_nxt;
    res_found_r <= res_found_nxt;
    res_mac_r   <= res_mac_nxt;
    res_port_r  <= res_port_nxt;
    res_full_r  <= res_full_nxt;
    out_found_r <= out_found_nxt;
    out_mac_r   <= out_mac_nxt;
    out_port_r  <= out_port_nxt;
    out_full_r  <= out_full_nxt;
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      slot_mem[cmp_idx_r] <= {mac_r, port_r};
    end
    rd_data_r <= slot_mem[rd_idx_r];
  end

  assign out_valid      = out_valid_r;
  assign out_found      = out_found_r;
  assign out_found_mac  = out_mac_r;
  assign out_found_port = out_port_r;
  assign out_table_full = out_full_r;

`include "mac_address_table_assert.svh"

  `MAT_ASSERT_NOW(a_full_not_found, out_valid_r && out_full_r, !out_found_r,
                  "table_full and found raised together")
  `MAT_ASSERT_NOW(a_miss_zero, out_valid_r && !out_found_r,
                  (out_mac_r == '0) && (out_port_r == '0),
                  "lookup miss carries nonzero address or port")
  `MAT_ASSERT_NOW(a_add_free_slot, mem_we, !valid_r[cmp_idx_r],
                  "add wrote over an occupied slot")
  `MAT_ASSERT_NEXT(a_clear_empties, in_fire && (in_cmd == CMD_CLEAR), valid_r == '0,
                   "clear left valid slots behind")

endmodule

@@ tb/sv/mac_address_table_tb.sv @@
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// mac_address_table_tb
// Self-checking bench for the learned MAC address table: adds, lookups by
// address and by port, removes, clears and reserved commands go in through
// the request channel. A shadow copy of the slot table predicts every reply,
// and each reply is compared field by field in arrival order.
// -----------------------------------------------------------------------------
module mac_address_table_tb;
  import mat_pkg::*;

  // Reserved command codes; the block must treat them as no-ops.
  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  localparam int RANDOM_REQUESTS = 1225;
  localparam int STALL_LIMIT     = 4000; // cycles with no handshake at all
  localparam int DRAIN_CYCLES    = 100;  // quiet stretch after the last owed reply
  localparam int PRESSURE_AT     = 400;  // replies seen before the long hold
  localparam int PRESSURE_HOLD   = 300;
  localparam int MAC_POOL_DEPTH  = 32;

  typedef struct packed {
    logic              found;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
    logic              full;
  } table_reply_t;

  typedef enum {FILL_UP, CHURN} traffic_mix_t;

  // ---------------------------------------------------------------------------
  // Shadow of the slot table plus the queue of replies still owed by the block.
  // ---------------------------------------------------------------------------
  class table_shadow_t;
    bit                slot_used [TABLE_ENTRIES];
    logic [MAC_W-1:0]  slot_mac  [TABLE_ENTRIES];
    logic [PORT_W-1:0] slot_port [TABLE_ENTRIES];
    table_reply_t      replies_due[$];
    int                mismatches;

    function new();
      slot_used  = '{default: 1'b0};
      mismatches = 0;
    endfunction

    function int pending();
      return replies_due.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("ERROR: %s", msg);
    endtask

    function void note_request(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
                               logic [PORT_W-1:0] port);
      table_reply_t r;
      bit           placed;
      bit           hit;
      r = '0;
      case (cmd)
        CMD_ADD: begin
          if (int'(port) < PORT_COUNT) begin
            placed = 1'b0;
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (!slot_used[i]) begin
                slot_used[i] = 1'b1;
                slot_mac[i]  = mac;
                slot_port[i] = port;
                placed       = 1'b1;
                break;
              end
            end
            r.full = !placed;
          end
        end
        CMD_LOOKUP_MAC, CMD_LOOKUP_PORT: begin
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot_used[i]) begin
              hit = (cmd == CMD_LOOKUP_MAC) ? (slot_mac[i] == mac) : (slot_port[i] == port);
              if (hit) begin
                r.found = 1'b1;
                r.mac   = slot_mac[i];
                r.port  = slot_port[i];
                break;
              end
            end
          end
        end
        CMD_REMOVE: begin
          for (int i = 0; i < TABLE_ENTRIES; i++)
            if (slot_used[i] && slot_port[i] == port) slot_used[i] = 1'b0;
        end
        CMD_CLEAR: slot_used = '{default: 1'b0};
        default: ;
      endcase
      replies_due = {replies_due, r};
    endfunction

    task check_reply(table_reply_t got);
      table_reply_t want;
      if (replies_due.size() == 0) begin
        report($sformatf("reply with no request waiting: %p", got));
        return;
      end
      want = replies_due.pop_front();
      if (got.found !== want.found)
        report($sformatf("found %b, want %b", got.found, want.found));
      if (got.mac !== want.mac)
        report($sformatf("found_mac %h, want %h", got.mac, want.mac));
      if (got.port !== want.port)
        report($sformatf("found_port %0d, want %0d", got.port, want.port));
      if (got.full !== want.full)
        report($sformatf("table_full %b, want %b", got.full, want.full));
    endtask
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset and block ports; every input starts at a known value.
  // ---------------------------------------------------------------------------
  logic              clk         = 1'b0;
  logic              rst_n       = 1'b0;
  logic              in_valid    = 1'b0;
  logic              in_ready;
  logic [CMD_W-1:0]  in_cmd      = CMD_CLEAR;
  logic [MAC_W-1:0]  in_mac_addr = '0;
  logic [PORT_W-1:0] in_port_id  = '0;
  logic              out_valid;
  logic              out_ready   = 1'b0;
  logic              out_found;
  logic [MAC_W-1:0]  out_found_mac;
  logic [PORT_W-1:0] out_found_port;
  logic              out_table_full;

  table_shadow_t     shadow = new();
  logic [MAC_W-1:0]  mac_pool[$];   // recently learned addresses, reused for hits
  int                send_burst = 0;
  int                recv_burst = 0;
  int                replies_seen = 0;

  always #1 clk = ~clk;

  mac_address_table dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_mac_addr    (in_mac_addr),
    .in_port_id     (in_port_id),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_found      (out_found),
    .out_found_mac  (out_found_mac),
    .out_found_port (out_found_port),
    .out_table_full (out_table_full)
  );

  // Draw the idle cycles before the next handshake. Now and then start a
  // burst with no idling at all so back-to-back traffic gets exercised.
  function automatic int draw_wait(ref int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      burst_left = $urandom_range(15, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  // Offer one request, hold it until accepted, then hand it to the shadow.
  // Valid is only lowered when a gap follows, so it never drops and rises
  // in the same step.
  task automatic drive_request(logic [CMD_W-1:0] cmd, logic [MAC_W-1:0] mac,
                               logic [PORT_W-1:0] port);
    int gap;
    gap = draw_wait(send_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= cmd;
    in_mac_addr <= mac;
    in_port_id  <= port;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    shadow.note_request(cmd, mac, port);
    if (cmd == CMD_ADD) begin
      mac_pool = {mac_pool, mac};
      if (mac_pool.size() > MAC_POOL_DEPTH) void'(mac_pool.pop_front());
    end
  endtask

  function automatic logic [MAC_W-1:0] random_mac();
    logic [63:0] r;
    r = {$urandom, $urandom};
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return '1;
      default: return r[MAC_W-1:0];
    endcase
  endfunction

  // Favor a handful of hot ports so removes and port lookups find entries.
  function automatic logic [PORT_W-1:0] random_port();
    if ($urandom_range(0, 9) < 6) return PORT_W'($urandom_range(0, 7));
    return PORT_W'($urandom_range(0, PORT_COUNT - 1));
  endfunction

  // Pick an address for a lookup: mostly one already learned, else anything.
  function automatic logic [MAC_W-1:0] lookup_mac();
    if (mac_pool.size() > 0 && $urandom_range(0, 9) < 7)
      return mac_pool[$urandom_range(0, mac_pool.size() - 1)];
    return random_mac();
  endfunction

  // Issue one random request shaped by the current traffic mix. A fill-up
  // mix drives the table to full and past it; churn frees and reuses slots.
  task automatic random_request(traffic_mix_t mix);
    int               roll;
    logic [CMD_W-1:0] cmd;
    roll = $urandom_range(0, 99);
    if (mix == FILL_UP) begin
      if      (roll < 70) cmd = CMD_ADD;
      else if (roll < 85) cmd = CMD_LOOKUP_MAC;
      else if (roll < 95) cmd = CMD_LOOKUP_PORT;
      else if (roll < 98) cmd = CMD_REMOVE;
      else                cmd = CMD_RSVD_5;
    end else begin
      if      (roll < 35) cmd = CMD_ADD;
      else if (roll < 60) cmd = CMD_LOOKUP_MAC;
      else if (roll < 80) cmd = CMD_LOOKUP_PORT;
      else if (roll < 95) cmd = CMD_REMOVE;
      else if (roll < 97) cmd = CMD_CLEAR;
      else                cmd = CMD_RSVD_6;
    end
    // Spread reserved codes over all three values.
    if (cmd == CMD_RSVD_5 || cmd == CMD_RSVD_6) begin
      case ($urandom_range(0, 2))
        0:       cmd = CMD_RSVD_5;
        1:       cmd = CMD_RSVD_6;
        default: cmd = CMD_RSVD_7;
      endcase
    end
    drive_request(cmd, (cmd == CMD_LOOKUP_MAC) ? lookup_mac() : random_mac(), random_port());
  endtask

  // ---------------------------------------------------------------------------
  // Reply side: stall at random, hold off once for a long stretch so the
  // block backs up into its request channel, and check every reply taken.
  // ---------------------------------------------------------------------------
  initial begin
    int  stall;
    bit  pressure_done;
    pressure_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = draw_wait(recv_burst);
      if (!pressure_done && replies_seen >= PRESSURE_AT) begin
        stall         = PRESSURE_HOLD;
        pressure_done = 1'b1;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      shadow.check_reply('{out_found, out_found_mac, out_found_port, out_table_full});
      replies_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run if neither channel moves for too long.
  // ---------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus: directed corner cases, then random traffic in episodes.
  // ---------------------------------------------------------------------------
  initial begin
    int           sent;
    int           ep_len;
    bit           first_episode;
    traffic_mix_t mix;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Empty table: every lookup misses, a remove does nothing.
    drive_request(CMD_LOOKUP_MAC, '0, '0);
    drive_request(CMD_LOOKUP_PORT, '0, '0);
    drive_request(CMD_REMOVE, '0, 6'd5);
    // Learn extremes of address and port, two entries on port 63 and a
    // duplicate address on another port.
    drive_request(CMD_ADD, '0, '0);
    drive_request(CMD_ADD, '1, 6'd63);
    drive_request(CMD_ADD, 48'h0123_4567_89ab, 6'd63);
    drive_request(CMD_ADD, '1, 6'd1);
    // Duplicates resolve to the lowest slot.
    drive_request(CMD_LOOKUP_MAC, '1, '0);
    drive_request(CMD_LOOKUP_MAC, '0, '1);
    drive_request(CMD_LOOKUP_PORT, '1, 6'd63);
    drive_request(CMD_LOOKUP_PORT, '0, 6'd1);
    drive_request(CMD_LOOKUP_MAC, 48'haaaa_aaaa_aaaa, 6'd2);
    // Remove every entry on port 63, then check the holes.
    drive_request(CMD_REMOVE, '1, 6'd63);
    drive_request(CMD_LOOKUP_PORT, '0, 6'd63);
    drive_request(CMD_LOOKUP_MAC, '1, 6'd63);
    // The next add must land in the lowest freed slot.
    drive_request(CMD_ADD, 48'h5555_5555_5555, 6'd63);
    drive_request(CMD_LOOKUP_PORT, '0, 6'd63);
    // Reserved commands with every field bit set change nothing.
    drive_request(CMD_RSVD_5, '1, '1);
    drive_request(CMD_RSVD_6, '1, '1);
    drive_request(CMD_RSVD_7, '1, '1);
    drive_request(CMD_LOOKUP_MAC, 48'h5555_5555_5555, '0);
    // Clear empties everything at once.
    drive_request(CMD_CLEAR, '0, '0);
    drive_request(CMD_LOOKUP_MAC, '0, '0);
    drive_request(CMD_ADD, 48'haaaa_aaaa_aaaa, 6'd42);
    drive_request(CMD_LOOKUP_MAC, 48'haaaa_aaaa_aaaa, '0);

    // Random part: open with a fill-up episode so overflow is reached early.
    sent          = 0;
    first_episode = 1'b1;
    while (sent < RANDOM_REQUESTS) begin
      mix = (first_episode || $urandom_range(0, 1) == 0) ? FILL_UP : CHURN;
      if (!first_episode && $urandom_range(0, 3) == 0) begin
        drive_request(CMD_CLEAR, random_mac(), random_port());
        sent++;
      end
      first_episode = 1'b0;
      ep_len = $urandom_range(60, 140);
      for (int k = 0; k < ep_len && sent < RANDOM_REQUESTS; k++) begin
        random_request(mix);
        sent++;
      end
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed reply, then watch for strays.
    while (shadow.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (shadow.mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
